FILE: rtl/bpa_pkg.sv
// Types and constants shared by the buddy page allocator.
// Holds the request, response and page table entry layouts. No dependencies.
package bpa_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFREE   = 2'd1;
  localparam logic [1:0] ST_BADFREE  = 2'd2;
  localparam logic [1:0] ST_BADORDER = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] order;
    logic [9:0] page_index;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] block_start;
    logic [3:0] final_order;
  } bpa_rsp_t;

  typedef struct packed {
    logic [3:0] order;
    logic       head;
    logic       busy;
  } page_ent_t;

endpackage

FILE: rtl/buddy_page_allocator.sv
// Buddy page allocator: NUM_PAGES pages kept as power-of-two blocks of order 0 to
// MAX_ORDER in one page table RAM (order, head and busy bit per page). After reset a
// clearing pass writes the initial table entry of every page; no request is taken
// then. An allocate is accepted, then walks the block heads from page 0, reading
// each head and then comparing it (the next head address depends on the order read
// back), stopping early at the first free block of exactly the requested order, or
// after the last head otherwise. Then the block is picked, each split level writes
// its free lower half, a final write marks the block busy, and the response is moved
// out. A free is accepted with a read of its entry, which is then compared; each
// merge level reads the buddy and compares it, a final write sets the merged head,
// and the response is moved out. Everything goes through the single table RAM, one
// access per cycle, one request at a time.
// Depends on bpa_pkg and bpa_ram.
module buddy_page_allocator #(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_ORDER = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpa_pkg::bpa_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpa_pkg::bpa_rsp_t out_rsp_o
);
  import bpa_pkg::*;

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int BLK  = 1 << MAX_ORDER;
  localparam int FULL = (NUM_PAGES / BLK) * BLK;
  localparam logic [3:0]  MaxOrd = 4'(MAX_ORDER);
  localparam logic [AW:0] NumP   = (AW+1)'(NUM_PAGES);
  localparam logic [AW:0] FullP  = (AW+1)'(FULL);
  localparam logic [AW:0] BlkM   = (AW+1)'(BLK - 1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_AREQ  = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_APICK = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_MREQ  = 4'd7;
  localparam logic [3:0] S_MCHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [AW:0]   ptr_q, ptr_d;
  logic [AW-1:0] p_q, p_d;
  logic [3:0]    o_q, o_d, req_q, req_d;
  logic          bv_q, bv_d;
  logic [3:0]    bo_q, bo_d;
  logic [AW-1:0] ba_q, ba_d;
  bpa_rsp_t      res_q, res_d, out_q, out_d;
  logic          ov_q, ov_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  page_ent_t     wdata, rdata;

  bpa_ram #(.Width($bits(page_ent_t)), .Depth(NUM_PAGES)) u_tab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [AW:0]   size, bud_ext, psz;
  logic [AW-1:0] bud;
  logic [AW:0]   pg_ext;
  logic [31:0]   pw;

  assign size    = (AW+1)'(1) << o_q;
  assign bud_ext = {1'b0, p_q} ^ size;
  assign bud     = bud_ext[AW-1:0];
  assign psz     = (AW+1)'(1) << (o_q - 4'd1);
  assign pg_ext  = (AW+1)'(in_req_i.page_index);
  assign pw      = 32'(p_q);

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    p_d = p_q;
    o_d = o_q;
    req_d = req_q;
    bv_d = bv_q;
    bo_d = bo_q;
    ba_d = ba_q;
    res_d = res_q;
    out_d = out_q;
    ov_d = ov_q;
    we = 1'b0;
    re = 1'b0;
    waddr = p_q;
    raddr = p_q;
    wdata = '0;
    in_ready_o = (state_q == S_IDLE);

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        we = 1'b1;
        waddr = ptr_q[AW-1:0];
        if (ptr_q < FullP) begin
          wdata.head  = ((ptr_q & BlkM) == '0);
          wdata.order = wdata.head ? MaxOrd : 4'd0;
        end else begin
          wdata.head = 1'b1;
        end
        ptr_d = ptr_q + (AW+1)'(1);
        if (ptr_d == NumP) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i.order;
          res_d = '0;
          if (in_req_i.order > MaxOrd) begin
            res_d.status = ST_BADORDER;
            state_d = S_DONE;
          end else if (in_req_i.func == FUNC_ALLOC) begin
            ptr_d = '0;
            bv_d = 1'b0;
            state_d = S_AREQ;
          end else if (pg_ext >= NumP) begin
            res_d.status = ST_BADFREE;
            state_d = S_DONE;
          end else begin
            re = 1'b1;
            raddr = pg_ext[AW-1:0];
            p_d = pg_ext[AW-1:0];
            state_d = S_FCHK;
          end
        end
      end
      S_AREQ: begin
        if (ptr_q >= NumP) begin
          state_d = S_APICK;
        end else begin
          re = 1'b1;
          raddr = ptr_q[AW-1:0];
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        ptr_d = ptr_q + ((AW+1)'(1) << rdata.order);
        state_d = S_AREQ;
        if (rdata.head && !rdata.busy && rdata.order >= req_q
            && (!bv_q || rdata.order < bo_q)) begin
          bv_d = 1'b1;
          bo_d = rdata.order;
          ba_d = ptr_q[AW-1:0];
          // An exact fit at the lowest address cannot be beaten.
          if (rdata.order == req_q) begin
            state_d = S_APICK;
          end
        end
      end
      S_APICK: begin
        if (!bv_q) begin
          res_d.status = ST_NOFREE;
          state_d = S_DONE;
        end else begin
          p_d = ba_q;
          o_d = bo_q;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        wdata.head = 1'b1;
        if (o_q > req_q) begin
          // Lower half stays free; continue in the upper half.
          wdata.order = o_q - 4'd1;
          p_d = p_q + psz[AW-1:0];
          o_d = o_q - 4'd1;
        end else begin
          wdata.order = req_q;
          wdata.busy = 1'b1;
          res_d.status = ST_OK;
          res_d.block_start = pw[9:0];
          res_d.final_order = req_q;
          state_d = S_DONE;
        end
      end
      S_FCHK: begin
        if (!(rdata.head && rdata.busy && rdata.order == req_q)) begin
          res_d.status = ST_BADFREE;
          state_d = S_DONE;
        end else begin
          o_d = req_q;
          state_d = S_MREQ;
        end
      end
      S_MREQ: begin
        if (o_q < MaxOrd && (bud_ext + size) <= NumP) begin
          re = 1'b1;
          raddr = bud;
          state_d = S_MCHK;
        end else begin
          we = 1'b1;
          wdata.head = 1'b1;
          wdata.order = o_q;
          res_d.status = ST_OK;
          res_d.block_start = pw[9:0];
          res_d.final_order = o_q;
          state_d = S_DONE;
        end
      end
      S_MCHK: begin
        if (rdata.head && !rdata.busy && rdata.order == o_q) begin
          // The upper of the pair stops being a head.
          we = 1'b1;
          waddr = (p_q < bud) ? bud : p_q;
          p_d = (p_q < bud) ? p_q : bud;
          o_d = o_q + 4'd1;
          state_d = S_MREQ;
        end else begin
          we = 1'b1;
          wdata.head = 1'b1;
          wdata.order = o_q;
          res_d.status = ST_OK;
          res_d.block_start = pw[9:0];
          res_d.final_order = o_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          out_d = res_q;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ptr_q   <= '0;
      ov_q    <= 1'b0;
      bv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      ov_q    <= ov_d;
      bv_q    <= bv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    o_q   <= o_d;
    req_q <= req_d;
    bo_q  <= bo_d;
    ba_q  <= ba_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_rsp_o   = out_q;

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !we) else $error("table written while idle");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != ST_OK) |->
      (out_rsp_o.block_start == '0 && out_rsp_o.final_order == '0))
    else $error("error response carries nonzero fields");
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.final_order <= MaxOrd)
    else $error("response order out of range");
endmodule

FILE: rtl/bpa_ram.sv
// Generic single-clock RAM, one write port and one read port.
// Read data is registered. No dependencies.
module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: tb/tb_buddy_page_allocator.sv
// Testbench for the buddy page allocator: drives allocate and free requests, keeps
// its own copy of the page table to predict each response, and checks every field.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
module tb_buddy_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int NPAGES   = 1024;
  localparam int TOP_ORD  = 8;
  localparam int N_ITEMS  = 1850;
  localparam int N_QUIET  = 150;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  bpa_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b1;
  bpa_rsp_t out_rsp_o;

  buddy_page_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow page table.
  logic [3:0] tbl_order [NPAGES];
  logic       tbl_head  [NPAGES];
  logic       tbl_busy  [NPAGES];

  typedef struct packed {
    logic [9:0] page;
    logic [3:0] order;
  } live_blk_t;

  live_blk_t live_q[$];
  bpa_req_t  pend_q[$];
  bpa_rsp_t  rsp_q[$];
  int        n_err = 0;
  bit        drv_idle_en = 1'b1;
  bit        rcv_stall_en = 1'b1;

  task automatic table_reset();
    for (int i = 0; i < NPAGES; i++) begin
      tbl_head[i]  = (i % (1 << TOP_ORD)) == 0;
      tbl_order[i] = tbl_head[i] ? 4'(TOP_ORD) : 4'd0;
      tbl_busy[i]  = 1'b0;
    end
  endtask

  task automatic predict_alloc(input int req, output bpa_rsp_t r);
    int o;
    int p;
    bit found;
    found = 1'b0;
    p = 0;
    for (o = req; o <= TOP_ORD; o++) begin
      for (int i = 0; i < NPAGES; i++) begin
        if (tbl_head[i] && !tbl_busy[i] && tbl_order[i] == o) begin
          p = i;
          found = 1'b1;
          break;
        end
      end
      if (found) break;
    end
    if (!found) begin
      r = '{ST_NOFREE, 10'd0, 4'd0};
      return;
    end
    // Keep the lower half free at each level and walk into the upper half.
    while (o > req) begin
      o--;
      tbl_order[p] = 4'(o);
      p += 1 << o;
      tbl_head[p]  = 1'b1;
      tbl_order[p] = 4'(o);
    end
    tbl_head[p]  = 1'b1;
    tbl_busy[p]  = 1'b1;
    tbl_order[p] = 4'(req);
    live_q.push_back('{10'(p), 4'(req)});
    r = '{ST_OK, 10'(p), 4'(req)};
  endtask

  task automatic predict_free(input int req, input int pg, output bpa_rsp_t r);
    int o;
    int p;
    int sz;
    int b;
    int lo;
    int hi;
    o = req;
    p = pg;
    if (!tbl_head[pg] || !tbl_busy[pg] || tbl_order[pg] != req) begin
      r = '{ST_BADFREE, 10'd0, 4'd0};
      return;
    end
    tbl_busy[p] = 1'b0;
    foreach (live_q[k]) begin
      if (live_q[k].page == pg) begin
        live_q.delete(k);
        break;
      end
    end
    while (o < TOP_ORD) begin
      sz = 1 << o;
      b  = p ^ sz;
      if (b + sz > NPAGES) break;
      if (!(tbl_head[b] && !tbl_busy[b] && tbl_order[b] == o)) break;
      lo = (p < b) ? p : b;
      hi = (p < b) ? b : p;
      tbl_head[hi]  = 1'b0;
      tbl_order[hi] = 4'd0;
      o++;
      tbl_order[lo] = 4'(o);
      p = lo;
    end
    r = '{ST_OK, 10'(p), 4'(o)};
  endtask

  task automatic predict_rsp(input bpa_req_t q);
    bpa_rsp_t r;
    if (q.order > TOP_ORD) r = '{ST_BADORDER, 10'd0, 4'd0};
    else if (q.func == FUNC_ALLOC) predict_alloc(int'(q.order), r);
    else predict_free(int'(q.order), int'(q.page_index), r);
    rsp_q.push_back(r);
  endtask

  // Driver: present one request at a time, with random idle bursts between them.
  int drv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_req_i   <= pend_q.pop_front();
        in_valid_i <= 1'b1;
        if (drv_idle_en && $urandom_range(3, 0) == 0) drv_gap = $urandom_range(14, 1);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Accepted requests update the shadow table.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_rsp(in_req_i);
  end

  // Receiver stalls in bursts.
  int rcv_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (rcv_stall > 0) begin
      rcv_stall--;
      out_ready_i <= 1'b0;
    end else if (rcv_stall_en && $urandom_range(5, 0) == 0) begin
      rcv_stall = $urandom_range(13, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    bpa_rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d start=%0d order=%0d", $time,
                 out_rsp_o.status, out_rsp_o.block_start, out_rsp_o.final_order);
        n_err++;
      end else begin
        e = rsp_q.pop_front();
        if (out_rsp_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_rsp_o.status);
          n_err++;
        end
        if (out_rsp_o.block_start !== e.block_start) begin
          $display("%0t: block_start expected %0d actual %0d", $time, e.block_start,
                   out_rsp_o.block_start);
          n_err++;
        end
        if (out_rsp_o.final_order !== e.final_order) begin
          $display("%0t: final_order expected %0d actual %0d", $time, e.final_order,
                   out_rsp_o.final_order);
          n_err++;
        end
      end
    end
  end

  task automatic add_req(input logic f, input int o, input int pg);
    pend_q.push_back('{f, 4'(o), 10'(pg)});
  endtask

  // Block until every queued request has been answered. The check runs on the
  // falling edge so that all updates from the rising edge have settled.
  task automatic drain();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || rsp_q.size() != 0);
  endtask

  task automatic add_random();
    int k;
    live_blk_t blk;
    k = $urandom_range(99, 0);
    if (k < 8) begin
      // Noise: any field value, including orders past the top.
      add_req(1'($urandom_range(1, 0)), $urandom_range(15, 0), $urandom_range(1023, 0));
    end else if (live_q.size() != 0 && k < 55 - (live_q.size() > 40 ? 0 : 15)
                 + (live_q.size() > 40 ? 20 : 0)) begin
      blk = live_q[$urandom_range(live_q.size() - 1, 0)];
      if ($urandom_range(9, 0) == 0) add_req(FUNC_FREE, $urandom_range(TOP_ORD, 0), blk.page);
      else add_req(FUNC_FREE, blk.order, blk.page);
    end else if ($urandom_range(7, 0) == 0) begin
      add_req(FUNC_ALLOC, $urandom_range(TOP_ORD, 0), $urandom_range(1023, 0));
    end else begin
      add_req(FUNC_ALLOC, $urandom_range(3, 0), $urandom_range(1023, 0));
    end
  endtask

  initial begin
    int sent;
    int batch;
    table_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    add_req(FUNC_ALLOC, 9, 0);
    add_req(FUNC_ALLOC, 15, 1023);
    add_req(FUNC_FREE, 15, 0);
    add_req(FUNC_FREE, 0, 0);
    for (int i = 0; i < 4; i++) add_req(FUNC_ALLOC, TOP_ORD, 10'h3ff);
    add_req(FUNC_ALLOC, 0, 0);
    add_req(FUNC_FREE, 3, 256);
    add_req(FUNC_FREE, TOP_ORD, 5);
    for (int i = 0; i < 4; i++) add_req(FUNC_FREE, TOP_ORD, i * 256);
    add_req(FUNC_ALLOC, 0, 0);
    add_req(FUNC_ALLOC, 1, 0);
    add_req(FUNC_ALLOC, 2, 0);
    add_req(FUNC_FREE, 0, 255);
    add_req(FUNC_FREE, 0, 255);
    add_req(FUNC_FREE, 1, 252);
    add_req(FUNC_FREE, 2, 248);
    sent = pend_q.size();
    drain();

    // Random part in batches; each batch ends with the sender holding off
    // until every response is back.
    while (sent < N_ITEMS) begin
      drv_idle_en  = (sent < N_ITEMS - N_QUIET) && ($urandom_range(3, 0) != 0);
      rcv_stall_en = (sent < N_ITEMS - N_QUIET) && ($urandom_range(3, 0) != 0);
      batch = $urandom_range(30, 10);
      for (int i = 0; i < batch; i++) add_random();
      sent += batch;
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #150_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
